/* sv/adp_action_network_2x4x1_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the action network block
// Concurrent checks, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ADP_ACTION_NETWORK_2X4X1_TOP_ASSERT_SVH
`define ADP_ACTION_NETWORK_2X4X1_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ADP_AN_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("adp_an: check failed");
`define ADP_AN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("adp_an: check failed");
`else
`define ADP_AN_ASSERT(label, prop)
`define ADP_AN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/adp_an_pkg.sv */
// ---------------------------------------------------------------------------
// adp_an_pkg
// Shared constants, types, activation table and saturation for the network.
// ---------------------------------------------------------------------------
package adp_an_pkg;

	localparam int HIDDEN_UNITS = 4;
	localparam int HID_BITS     = $clog2(HIDDEN_UNITS);
	localparam int FRAC_BITS    = 24;
	localparam int ACT_DEPTH    = 256;
	localparam int TAB_BITS     = $clog2(ACT_DEPTH);
	localparam int TAB_SHIFT    = FRAC_BITS + 3 - TAB_BITS;
	localparam int TAB_W        = FRAC_BITS + 1;
	localparam int MUL_W        = 33;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int ACC_W        = PROD_W - FRAC_BITS + 2;
	localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] HID_FLOOR =
		32'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);

	localparam logic [1:0] CMD_FWD    = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;

	localparam logic REG_LEARN_RATE  = 1'b0;
	localparam logic REG_REWARD_GAIN = 1'b1;

	typedef logic [TAB_W-1:0] act_tab_t [0:ACT_DEPTH];

	typedef struct packed {
		logic                     neg;
		logic [TAB_W-1:0]         lo;
		logic signed [TAB_W:0]    diff;
		logic [TAB_SHIFT-1:0]     frac;
	} act_front_t;

	// Table of tanh(x/2) over 0..8, built at elaboration.
	function automatic act_tab_t build_act_tab();
		act_tab_t    tab;
		logic [63:0] y, term, sum, e, num, den, q, r;
		for (int i = 0; i <= ACT_DEPTH; i++) begin
			// Point i sits at x = 8 * i / ACT_DEPTH; y is x / 64 in Q30.
			y    = 64'(i) << (30 - 3 - TAB_BITS);
			term = 64'd1 << 30;
			sum  = 64'd1 << 30;
			term = ((term * y) >> 30);
			sum  = sum - term;
			term = ((term * y) >> 30) / 64'd2;
			sum  = sum + term;
			term = ((term * y) >> 30) / 64'd3;
			sum  = sum - term;
			term = ((term * y) >> 30) / 64'd4;
			sum  = sum + term;
			term = ((term * y) >> 30) / 64'd5;
			sum  = sum - term;
			term = ((term * y) >> 30) / 64'd6;
			sum  = sum + term;
			if ($signed(sum) < 0)
				e = 64'd0;
			else if (sum > (64'd1 << 30))
				e = 64'd1 << 30;
			else
				e = sum;
			for (int n = 0; n < 6; n++)
				e = (e * e + (64'd1 << 29)) >> 30;
			num = ((64'd1 << 30) - e) << FRAC_BITS;
			den = (64'd1 << 30) + e;
			num = num + (den >> 1);
			q = '0;
			r = '0;
			for (int b = 63; b >= 0; b--) begin
				r = {r[62:0], num[b]};
				if (r >= den) begin
					r    = r - den;
					q[b] = 1'b1;
				end
			end
			tab[i] = q[TAB_W-1:0];
		end
		return tab;
	endfunction

	localparam act_tab_t ACT_TAB = build_act_tab();

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [31:0] res;
		if (v > PROD_W'(32'sh7fffffff))
			res = 32'sh7fffffff;
		else if (v < PROD_W'(-33'sh80000000))
			res = -32'sh80000000;
		else
			res = v[31:0];
		return res;
	endfunction

endpackage

/* sv/adp_an_mul.sv */
// ---------------------------------------------------------------------------
// adp_an_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module adp_an_mul (
	input  logic                                   clk,
	input  logic signed [adp_an_pkg::MUL_W-1:0]    a,
	input  logic signed [adp_an_pkg::MUL_W-1:0]    b,
	output logic signed [adp_an_pkg::PROD_W-1:0]   prod
);

	logic signed [adp_an_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

/* sv/adp_an_act.sv */
// ---------------------------------------------------------------------------
// adp_an_act
// Activation lookup: table front end and interpolation back end.
// ---------------------------------------------------------------------------
module adp_an_act (
	input  logic signed [adp_an_pkg::ACC_W-1:0]    x,
	output adp_an_pkg::act_front_t                 front,
	input  adp_an_pkg::act_front_t                 front_q,
	input  logic signed [adp_an_pkg::PROD_W-1:0]   prod,
	output logic signed [31:0]                     res
);

	logic [adp_an_pkg::ACC_W-1:0]      mag;
	logic                              big;
	logic [adp_an_pkg::TAB_BITS-1:0]   idx;
	logic [adp_an_pkg::TAB_W-1:0]      lo, hi;
	logic signed [adp_an_pkg::PROD_W-1:0] r;

	always_comb begin
		mag = x[adp_an_pkg::ACC_W-1] ? adp_an_pkg::ACC_W'(-x) : adp_an_pkg::ACC_W'(x);
		big = |mag[adp_an_pkg::ACC_W-1:adp_an_pkg::FRAC_BITS+3];
		idx = mag[adp_an_pkg::FRAC_BITS+2:adp_an_pkg::TAB_SHIFT];
		if (big) begin
			lo = adp_an_pkg::ACT_TAB[adp_an_pkg::ACT_DEPTH];
			hi = lo;
		end else begin
			lo = adp_an_pkg::ACT_TAB[idx];
			hi = adp_an_pkg::ACT_TAB[{1'b0, idx} + (adp_an_pkg::TAB_BITS+1)'(1)];
		end
		front.neg  = x[adp_an_pkg::ACC_W-1];
		front.lo   = lo;
		front.diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
		front.frac = big ? '0 : mag[adp_an_pkg::TAB_SHIFT-1:0];
	end

	// The product holds diff * frac; the arithmetic shift floors it.
	always_comb begin
		r   = $signed({{(adp_an_pkg::PROD_W-adp_an_pkg::TAB_W){1'b0}}, front_q.lo})
			+ (prod >>> adp_an_pkg::TAB_SHIFT);
		res = front_q.neg ? 32'(-r) : 32'(r);
	end

endmodule

/* sv/adp_action_network_2x4x1_top.sv */
// ---------------------------------------------------------------------------
// adp_action_network_2x4x1_top
// Action network of an adaptive dynamic programming controller (2-4-1 MLP).
// ---------------------------------------------------------------------------
// Input items (cmd plus operands) arrive on in_valid/in_stall and each yields
// one result item, the stored network output, on out_valid/out_stall.
// A forward item, a weight update, a load and an unused command each end in the
// done state, which publishes the result and returns the block to idle at once,
// so the next item can be accepted while the result is published. The block
// handles one item at a time: all products go through a single registered
// 33x33 multiplier under a small sequencer, and in_stall is high while the
// sequencer runs.
// A finished result sits in the output register; the next item is accepted
// while it waits, and the block only holds before publishing a new result
// if the receiver still stalls the previous one.
// Configuration (learn_rate at index 0, reward_gain at index 1) is written
// via wr_en/wr_index/wr_data; the user must write it only while the block is
// idle, which the block does not enforce. Reset clears all weights, the latched
// state inputs, hidden outputs and output; learn_rate, reward_gain to defaults.
// ---------------------------------------------------------------------------
module adp_action_network_2x4x1_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [31:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] state_pos,
	input  logic signed [31:0] state_rate,
	input  logic [3:0]         weight_index,
	input  logic signed [31:0] weight_value,
	input  logic signed [31:0] cost_value,
	input  logic signed [31:0] cost_slope,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [25:0] action_value
);

	`include "adp_action_network_2x4x1_top_assert.svh"

	localparam int ST_W = 6;
	localparam logic [ST_W-1:0] ST_IDLE = 6'd0;
	localparam logic [ST_W-1:0] ST_FM0  = 6'd1;
	localparam logic [ST_W-1:0] ST_FM1  = 6'd2;
	localparam logic [ST_W-1:0] ST_FA   = 6'd3;
	localparam logic [ST_W-1:0] ST_ACT0 = 6'd4;
	localparam logic [ST_W-1:0] ST_ACT1 = 6'd5;
	localparam logic [ST_W-1:0] ST_OM   = 6'd6;
	localparam logic [ST_W-1:0] ST_OA   = 6'd7;
	localparam logic [ST_W-1:0] ST_U0   = 6'd8;
	localparam logic [ST_W-1:0] ST_U1   = 6'd9;
	localparam logic [ST_W-1:0] ST_U2   = 6'd10;
	localparam logic [ST_W-1:0] ST_U3   = 6'd11;
	localparam logic [ST_W-1:0] ST_U4   = 6'd12;
	localparam logic [ST_W-1:0] ST_U5   = 6'd13;
	localparam logic [ST_W-1:0] ST_U6   = 6'd14;
	localparam logic [ST_W-1:0] ST_J0   = 6'd15;
	localparam logic [ST_W-1:0] ST_J1   = 6'd16;
	localparam logic [ST_W-1:0] ST_J2   = 6'd17;
	localparam logic [ST_W-1:0] ST_J3   = 6'd18;
	localparam logic [ST_W-1:0] ST_J4   = 6'd19;
	localparam logic [ST_W-1:0] ST_J5   = 6'd20;
	localparam logic [ST_W-1:0] ST_J6   = 6'd21;
	localparam logic [ST_W-1:0] ST_J7   = 6'd22;
	localparam logic [ST_W-1:0] ST_J8   = 6'd23;
	localparam logic [ST_W-1:0] ST_J9   = 6'd24;
	localparam logic [ST_W-1:0] ST_J10  = 6'd25;
	localparam logic [ST_W-1:0] ST_J11  = 6'd26;
	localparam logic [ST_W-1:0] ST_J12  = 6'd27;
	localparam logic [ST_W-1:0] ST_J13  = 6'd28;
	localparam logic [ST_W-1:0] ST_J14  = 6'd29;
	localparam logic [ST_W-1:0] ST_DONE = 6'd30;

	localparam int MW = adp_an_pkg::MUL_W;
	localparam int PW = adp_an_pkg::PROD_W;
	localparam int AW = adp_an_pkg::ACC_W;
	localparam int FB = adp_an_pkg::FRAC_BITS;
	localparam int HB = adp_an_pkg::HID_BITS;
	localparam logic [HB-1:0] J_LAST = HB'(adp_an_pkg::HIDDEN_UNITS - 1);
	localparam logic signed [31:0] HF = adp_an_pkg::HID_FLOOR;

	logic [ST_W-1:0]    state_q;
	logic [HB-1:0]      j_q;
	logic               act_out_q;
	logic [31:0]        learn_rate_q;
	logic [15:0]        reward_gain_q;
	logic signed [31:0] x_q [0:1];
	logic signed [31:0] h_q [0:adp_an_pkg::HIDDEN_UNITS-1];
	logic signed [31:0] o_q;
	logic signed [31:0] w1_q [0:2*adp_an_pkg::HIDDEN_UNITS-1];
	logic signed [31:0] w2_q [0:adp_an_pkg::HIDDEN_UNITS-1];
	logic signed [31:0] cost_q, slope_q, base_q, d_q, dh_q, g_q, gk_q;
	logic signed [AW-1:0] acc_q;
	adp_an_pkg::act_front_t front, front_q;
	logic               out_valid_q;
	logic signed [25:0] action_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-FB-1:0] q_fb;
	logic signed [PW-1:0] lr_step;
	logic signed [31:0] act_res, hid_val, half_one_m;
	logic signed [31:0] w_cur;

	adp_an_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	adp_an_act u_act (
		.x       (acc_q),
		.front   (front),
		.front_q (front_q),
		.prod    (prod),
		.res     (act_res)
	);

	assign q_fb    = prod[PW-1:FB];
	assign lr_step = PW'($signed(prod[PW-1:32]));
	// (1 - p) / 2 for the derivative terms, p being the last floored square.
	assign half_one_m = 32'((PW'(adp_an_pkg::ONE_Q) - PW'(q_fb)) >>> 1);

	always_comb begin
		if (act_res > 0 && act_res < adp_an_pkg::HID_FLOOR)
			hid_val = adp_an_pkg::HID_FLOOR;
		else if (act_res < 0 && act_res > -adp_an_pkg::HID_FLOOR)
			hid_val = -adp_an_pkg::HID_FLOOR;
		else
			hid_val = act_res;
	end

	always_comb begin
		case (state_q)
			ST_J8:   w_cur = w1_q[{1'b0, j_q}];
			ST_J11:  w_cur = w1_q[{1'b1, j_q}];
			default: w_cur = w2_q[j_q];
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_FM0: begin
				mul_a = MW'(x_q[0]);
				mul_b = MW'(w1_q[{1'b0, j_q}]);
			end
			ST_FM1: begin
				mul_a = MW'(x_q[1]);
				mul_b = MW'(w1_q[{1'b1, j_q}]);
			end
			ST_ACT0: begin
				mul_a = MW'(front.diff);
				mul_b = MW'($signed({1'b0, front.frac}));
			end
			ST_OM: begin
				mul_a = MW'(h_q[j_q]);
				mul_b = MW'(w2_q[j_q]);
			end
			ST_U0: begin
				mul_a = MW'(o_q);
				mul_b = MW'(o_q);
			end
			ST_U1: begin
				mul_a = MW'(cost_q);
				mul_b = MW'(slope_q);
			end
			ST_U3: begin
				mul_a = MW'(base_q);
				mul_b = MW'($signed({1'b0, reward_gain_q}));
			end
			ST_U5: begin
				mul_a = MW'(base_q);
				mul_b = MW'(d_q);
			end
			ST_J0: begin
				mul_a = MW'(h_q[j_q]);
				mul_b = MW'(h_q[j_q]);
			end
			ST_J1: begin
				mul_a = MW'(base_q);
				mul_b = MW'(w2_q[j_q]);
			end
			ST_J3: begin
				mul_a = MW'(g_q);
				mul_b = MW'(dh_q);
			end
			ST_J5: begin
				mul_a = MW'(g_q);
				mul_b = MW'(x_q[0]);
			end
			ST_J7, ST_J10, ST_J13: begin
				mul_a = MW'($signed({1'b0, learn_rate_q}));
				mul_b = -MW'(gk_q);
			end
			ST_J8: begin
				mul_a = MW'(g_q);
				mul_b = MW'(x_q[1]);
			end
			ST_J11: begin
				mul_a = MW'(base_q);
				mul_b = MW'(h_q[j_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Working registers that need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cost_q  <= cost_value;
				slope_q <= cost_slope;
			end
			ST_FM1:  acc_q <= AW'(q_fb);
			ST_FA:   acc_q <= acc_q + AW'(q_fb);
			ST_ACT0: front_q <= front;
			ST_ACT1: acc_q <= '0;
			ST_OA:   acc_q <= acc_q + AW'(q_fb);
			ST_U1:   d_q <= half_one_m;
			ST_U2:   base_q <= adp_an_pkg::sat32(PW'(q_fb));
			ST_U4:   base_q <= adp_an_pkg::sat32(prod >>> 8);
			ST_U6:   base_q <= adp_an_pkg::sat32(PW'(q_fb));
			ST_J1:   dh_q <= half_one_m;
			ST_J2:   g_q <= adp_an_pkg::sat32(PW'(q_fb));
			ST_J4:   g_q <= adp_an_pkg::sat32(PW'(q_fb));
			ST_J6, ST_J9, ST_J12: gk_q <= adp_an_pkg::sat32(PW'(q_fb));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			j_q           <= '0;
			act_out_q     <= 1'b0;
			learn_rate_q  <= 32'd42950;
			reward_gain_q <= 16'd256;
			x_q[0]        <= '0;
			x_q[1]        <= '0;
			o_q           <= '0;
			out_valid_q   <= 1'b0;
			action_q      <= '0;
			for (int i = 0; i < adp_an_pkg::HIDDEN_UNITS; i++) begin
				h_q[i]  <= '0;
				w2_q[i] <= '0;
			end
			for (int i = 0; i < 2 * adp_an_pkg::HIDDEN_UNITS; i++)
				w1_q[i] <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					adp_an_pkg::REG_LEARN_RATE:  learn_rate_q  <= wr_data;
					adp_an_pkg::REG_REWARD_GAIN: reward_gain_q <= wr_data[15:0];
					default: ;
				endcase
			end
			// In the done state the publishing branch below owns out_valid_q.
			if (out_valid_q && !out_stall && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						j_q <= '0;
						case (cmd)
							adp_an_pkg::CMD_FWD: begin
								x_q[0]    <= state_pos;
								x_q[1]    <= state_rate;
								act_out_q <= 1'b0;
								state_q   <= ST_FM0;
							end
							adp_an_pkg::CMD_LOAD: begin
								if (weight_index < 4'(2 * adp_an_pkg::HIDDEN_UNITS))
									w1_q[weight_index[HB:0]] <= weight_value;
								else if (weight_index < 4'(3 * adp_an_pkg::HIDDEN_UNITS))
									w2_q[weight_index[HB-1:0]] <= weight_value;
								state_q <= ST_DONE;
							end
							adp_an_pkg::CMD_UPDATE: state_q <= ST_U0;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_FM0:  state_q <= ST_FM1;
				ST_FM1:  state_q <= ST_FA;
				ST_FA:   state_q <= ST_ACT0;
				ST_ACT0: state_q <= ST_ACT1;
				ST_ACT1: begin
					if (act_out_q) begin
						o_q     <= act_res;
						state_q <= ST_DONE;
					end else begin
						h_q[j_q] <= hid_val;
						if (j_q == J_LAST) begin
							j_q     <= '0;
							state_q <= ST_OM;
						end else begin
							j_q     <= j_q + HB'(1);
							state_q <= ST_FM0;
						end
					end
				end
				ST_OM: state_q <= ST_OA;
				ST_OA: begin
					if (j_q == J_LAST) begin
						act_out_q <= 1'b1;
						state_q   <= ST_ACT0;
					end else begin
						j_q     <= j_q + HB'(1);
						state_q <= ST_OM;
					end
				end
				ST_U0:  state_q <= ST_U1;
				ST_U1:  state_q <= ST_U2;
				ST_U2:  state_q <= ST_U3;
				ST_U3:  state_q <= ST_U4;
				ST_U4:  state_q <= ST_U5;
				ST_U5:  state_q <= ST_U6;
				ST_U6:  state_q <= ST_J0;
				ST_J0:  state_q <= ST_J1;
				ST_J1:  state_q <= ST_J2;
				ST_J2:  state_q <= ST_J3;
				ST_J3:  state_q <= ST_J4;
				ST_J4:  state_q <= ST_J5;
				ST_J5:  state_q <= ST_J6;
				ST_J6:  state_q <= ST_J7;
				ST_J7:  state_q <= ST_J8;
				ST_J8: begin
					w1_q[{1'b0, j_q}] <= adp_an_pkg::sat32(PW'(w_cur) + lr_step);
					state_q <= ST_J9;
				end
				ST_J9:  state_q <= ST_J10;
				ST_J10: state_q <= ST_J11;
				ST_J11: begin
					w1_q[{1'b1, j_q}] <= adp_an_pkg::sat32(PW'(w_cur) + lr_step);
					state_q <= ST_J12;
				end
				ST_J12: state_q <= ST_J13;
				ST_J13: state_q <= ST_J14;
				ST_J14: begin
					w2_q[j_q] <= adp_an_pkg::sat32(PW'(w_cur) + lr_step);
					if (j_q == J_LAST) begin
						state_q <= ST_DONE;
					end else begin
						j_q     <= j_q + HB'(1);
						state_q <= ST_J0;
					end
				end
				ST_DONE: begin
					// Publish only once the previous result item has been taken.
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						action_q    <= o_q[25:0];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign action_value = action_q;

	`ADP_AN_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`ADP_AN_ASSERT_NEXT(a_out_from_done, !out_valid && state_q != ST_DONE, !out_valid)
	`ADP_AN_ASSERT(a_hid_floor, h_q[0] == 0 || h_q[0] >= HF || h_q[0] <= -HF)

endmodule
